/* rtl/rqsm_pkg.sv */
// Shared types, constants and helper functions for the RTOS queue object.
// Used by rqsm_datapath and rtos_queue_semaphore_mutex_core.
// No dependencies.
package rqsm_pkg;

    // Default sizes of the object.
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ITEM_BITS   = 32;
    localparam int DEF_MAX_TASKS   = 16;

    // Fixed field widths.
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int TASK_W    = 4;
    localparam int COUNT_W   = 5;
    localparam int STATUS_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CARRIES_DATA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COUNT = 2'd2;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] RESET_QUEUE_LENGTH  = 5'd16;
    localparam logic             RESET_CARRIES_DATA  = 1'b1;
    localparam logic [CFG_W-1:0] RESET_INITIAL_COUNT = 5'd0;

    // Request kinds.
    localparam logic KIND_SEND    = 1'b0;
    localparam logic KIND_RECEIVE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_PASS    = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_EMPTY   = 2'd2,
        STATUS_BLOCKED = 2'd3
    } status_t;

    // Queue length clamped to 1 .. cap.
    function automatic logic [COUNT_W-1:0] eff_length(input logic [CFG_W-1:0] ql,
                                                       input logic [COUNT_W-1:0] cap);
        logic [COUNT_W-1:0] n;
        begin
            n = ql;
            if (n == '0) begin
                n = COUNT_W'(1);
            end else if (n > cap) begin
                n = cap;
            end
            return n;
        end
    endfunction

    // Initial count clamped to the effective length.
    function automatic logic [COUNT_W-1:0] clamp_count(input logic [CFG_W-1:0] ic,
                                                        input logic [COUNT_W-1:0] len);
        begin
            return (ic > len) ? len : ic;
        end
    endfunction

endpackage

/* rtl/rqsm_ctrl.sv */
// Handshake controller for the RTOS queue object.
// Sequences one request at a time: accept, then hold the result until taken.
// Does not depend on rqsm_pkg.
module rqsm_ctrl (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    output logic exec_req
);

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;
    logic   m_valid_reg, m_valid_next;

    // A request is executed in the cycle it is accepted.
    assign exec_req = s_valid & s_ready_reg;
    assign s_ready  = s_ready_reg;
    assign m_valid  = m_valid_reg;

    // Next state and registered handshake outputs.
    always_comb begin
        state_next   = state_reg;
        s_ready_next = s_ready_reg;
        m_valid_next = m_valid_reg;
        case (state_reg)
            ST_IDLE: begin
                if (exec_req) begin
                    state_next   = ST_RESP;
                    s_ready_next = 1'b0;
                    m_valid_next = 1'b1;
                end
            end
            ST_RESP: begin
                if (m_ready) begin
                    state_next   = ST_IDLE;
                    s_ready_next = 1'b1;
                    m_valid_next = 1'b0;
                end
            end
            default: begin
                state_next   = ST_IDLE;
                s_ready_next = 1'b1;
                m_valid_next = 1'b0;
            end
        endcase
    end

    // State and output registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* rtl/rqsm_datapath.sv */
// Datapath of the RTOS queue object: configuration, ring buffer, count,
// mutex holder, waiter counters and result registers. Depends on rqsm_pkg.
module rqsm_datapath #(
    parameter int QUEUE_DEPTH = rqsm_pkg::DEF_QUEUE_DEPTH,
    parameter int ITEM_BITS   = rqsm_pkg::DEF_ITEM_BITS,
    parameter int MAX_TASKS   = rqsm_pkg::DEF_MAX_TASKS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          exec_req,
    input  logic                          s_kind,
    input  logic [ITEM_BITS-1:0]          s_item_data,
    input  logic [rqsm_pkg::TASK_W-1:0]   s_task_id,
    input  logic                          s_may_wait,
    input  logic                          cfg_write,
    input  logic [rqsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rqsm_pkg::CFG_W-1:0]    cfg_data,
    output logic [rqsm_pkg::STATUS_W-1:0] m_status,
    output logic [ITEM_BITS-1:0]          m_read_data,
    output logic                          m_wake_sender,
    output logic                          m_wake_receiver,
    output logic                          m_inherit_request,
    output logic                          m_disinherit_request,
    output logic [rqsm_pkg::TASK_W-1:0]   m_holder_task,
    output logic [rqsm_pkg::COUNT_W-1:0]  m_message_count
);
    import rqsm_pkg::*;

    localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CMP_W       = ((SLOT_W > COUNT_W) ? SLOT_W : COUNT_W) + 1;
    localparam int WAIT_W      = $clog2(MAX_TASKS + 1);
    localparam int DEPTH_CAP_I = (QUEUE_DEPTH > 31) ? 31 : QUEUE_DEPTH;
    localparam logic [COUNT_W-1:0] DEPTH_CAP = COUNT_W'(DEPTH_CAP_I);
    localparam logic [WAIT_W-1:0]  WAIT_MAX  = WAIT_W'(MAX_TASKS);

    // Configuration registers.
    logic [CFG_W-1:0] queue_length_reg, queue_length_next;
    logic             carries_data_reg, carries_data_next;
    logic [CFG_W-1:0] initial_count_reg, initial_count_next;

    // Object state.
    logic [SLOT_W-1:0]  write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0]  last_read_slot_reg, last_read_slot_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               holder_valid_reg, holder_valid_next;
    logic [TASK_W-1:0]  holder_id_reg, holder_id_next;
    logic [WAIT_W-1:0]  blocked_senders_reg, blocked_senders_next;
    logic [WAIT_W-1:0]  blocked_receivers_reg, blocked_receivers_next;

    // Result registers.
    status_t            status_reg, status_next;
    logic               wake_s_reg, wake_s_next;
    logic               wake_r_reg, wake_r_next;
    logic               inh_reg, inh_next;
    logic               dis_reg, dis_next;
    logic [TASK_W-1:0]  htask_reg, htask_next;
    logic               rd_pass_reg, rd_pass_next;

    // Ring buffer storage.
    logic [ITEM_BITS-1:0] item_store [QUEUE_DEPTH];
    logic [ITEM_BITS-1:0] rdata_reg;
    logic                 mem_we;
    logic                 mem_re;
    logic [SLOT_W-1:0]    rd_slot;

    logic [COUNT_W-1:0] eff_len;
    logic [COUNT_W-1:0] new_len;
    logic [CMP_W-1:0]   new_last;
    logic [CMP_W-1:0]   wr_inc;
    logic [CMP_W-1:0]   rd_inc;
    logic [SLOT_W-1:0]  wr_wrap;
    logic [SLOT_W-1:0]  rd_wrap;
    logic               cfg_hit;

    assign eff_len = eff_length(queue_length_reg, DEPTH_CAP);

    // Only a write to one of the defined registers reloads the object.
    assign cfg_hit = cfg_write &&
                     (cfg_index inside {CFG_QUEUE_LENGTH, CFG_CARRIES_DATA, CFG_INITIAL_COUNT});

    // Slot advance with wrap at the effective length.
    always_comb begin
        wr_inc  = CMP_W'(write_slot_reg) + CMP_W'(1);
        rd_inc  = CMP_W'(last_read_slot_reg) + CMP_W'(1);
        wr_wrap = (wr_inc >= CMP_W'(eff_len)) ? '0 : wr_inc[SLOT_W-1:0];
        rd_wrap = (rd_inc >= CMP_W'(eff_len)) ? '0 : rd_inc[SLOT_W-1:0];
    end

    // Configuration values after this cycle's write, used to reload the object.
    always_comb begin
        queue_length_next  = queue_length_reg;
        carries_data_next  = carries_data_reg;
        initial_count_next = initial_count_reg;
        if (cfg_write) begin
            if (cfg_index == CFG_QUEUE_LENGTH) begin
                queue_length_next = cfg_data;
            end else if (cfg_index == CFG_CARRIES_DATA) begin
                carries_data_next = cfg_data[0];
            end else if (cfg_index == CFG_INITIAL_COUNT) begin
                initial_count_next = cfg_data;
            end
        end
        new_len  = eff_length(queue_length_next, DEPTH_CAP);
        new_last = CMP_W'(new_len) - CMP_W'(1);
    end

    // Per-request state update and result.
    always_comb begin
        write_slot_next        = write_slot_reg;
        last_read_slot_next    = last_read_slot_reg;
        count_next             = count_reg;
        holder_valid_next      = holder_valid_reg;
        holder_id_next         = holder_id_reg;
        blocked_senders_next   = blocked_senders_reg;
        blocked_receivers_next = blocked_receivers_reg;
        status_next            = status_reg;
        wake_s_next            = wake_s_reg;
        wake_r_next            = wake_r_reg;
        inh_next               = inh_reg;
        dis_next               = dis_reg;
        htask_next             = htask_reg;
        rd_pass_next           = rd_pass_reg;
        mem_we                 = 1'b0;
        mem_re                 = 1'b0;
        rd_slot                = rd_wrap;

        if (exec_req) begin
            status_next  = STATUS_PASS;
            wake_s_next  = 1'b0;
            wake_r_next  = 1'b0;
            inh_next     = 1'b0;
            dis_next     = 1'b0;
            htask_next   = '0;
            rd_pass_next = 1'b0;
            if (s_kind == KIND_SEND) begin
                if (count_reg < eff_len) begin
                    // Send or give passes.
                    if (carries_data_reg) begin
                        mem_we          = 1'b1;
                        write_slot_next = wr_wrap;
                    end
                    count_next = count_reg + COUNT_W'(1);
                    if (holder_valid_reg) begin
                        dis_next          = 1'b1;
                        htask_next        = holder_id_reg;
                        holder_valid_next = 1'b0;
                    end
                    if (blocked_receivers_reg != '0) begin
                        wake_r_next            = 1'b1;
                        blocked_receivers_next = blocked_receivers_reg - WAIT_W'(1);
                    end
                end else if (!s_may_wait) begin
                    status_next = STATUS_FULL;
                end else begin
                    if (blocked_senders_reg < WAIT_MAX) begin
                        blocked_senders_next = blocked_senders_reg + WAIT_W'(1);
                    end
                    status_next = STATUS_BLOCKED;
                end
            end else begin
                if (count_reg != '0) begin
                    // Receive or take passes.
                    if (carries_data_reg) begin
                        last_read_slot_next = rd_wrap;
                        mem_re              = 1'b1;
                        rd_pass_next        = 1'b1;
                    end
                    count_next = count_reg - COUNT_W'(1);
                    if ((eff_len == COUNT_W'(1)) && !carries_data_reg) begin
                        holder_valid_next = 1'b1;
                        holder_id_next    = s_task_id;
                    end
                    if (blocked_senders_reg != '0) begin
                        wake_s_next          = 1'b1;
                        blocked_senders_next = blocked_senders_reg - WAIT_W'(1);
                    end
                end else if (!s_may_wait) begin
                    status_next = STATUS_EMPTY;
                end else begin
                    if (holder_valid_reg) begin
                        inh_next   = 1'b1;
                        htask_next = holder_id_reg;
                    end
                    if (blocked_receivers_reg < WAIT_MAX) begin
                        blocked_receivers_next = blocked_receivers_reg + WAIT_W'(1);
                    end
                    status_next = STATUS_BLOCKED;
                end
            end
        end

        // A configuration write reloads the object as at reset.
        if (cfg_hit) begin
            write_slot_next        = '0;
            last_read_slot_next    = new_last[SLOT_W-1:0];
            count_next             = clamp_count(initial_count_next, new_len);
            holder_valid_next      = 1'b0;
            holder_id_next         = '0;
            blocked_senders_next   = '0;
            blocked_receivers_next = '0;
        end
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            queue_length_reg      <= RESET_QUEUE_LENGTH;
            carries_data_reg      <= RESET_CARRIES_DATA;
            initial_count_reg     <= RESET_INITIAL_COUNT;
            write_slot_reg        <= '0;
            last_read_slot_reg    <= SLOT_W'(CMP_W'(eff_length(RESET_QUEUE_LENGTH, DEPTH_CAP))
                                            - CMP_W'(1));
            count_reg             <= clamp_count(RESET_INITIAL_COUNT,
                                                 eff_length(RESET_QUEUE_LENGTH, DEPTH_CAP));
            holder_valid_reg      <= 1'b0;
            holder_id_reg         <= '0;
            blocked_senders_reg   <= '0;
            blocked_receivers_reg <= '0;
        end else begin
            queue_length_reg      <= queue_length_next;
            carries_data_reg      <= carries_data_next;
            initial_count_reg     <= initial_count_next;
            write_slot_reg        <= write_slot_next;
            last_read_slot_reg    <= last_read_slot_next;
            count_reg             <= count_next;
            holder_valid_reg      <= holder_valid_next;
            holder_id_reg         <= holder_id_next;
            blocked_senders_reg   <= blocked_senders_next;
            blocked_receivers_reg <= blocked_receivers_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        wake_s_reg  <= wake_s_next;
        wake_r_reg  <= wake_r_next;
        inh_reg     <= inh_next;
        dis_reg     <= dis_next;
        htask_reg   <= htask_next;
        rd_pass_reg <= rd_pass_next;
    end

    // Ring buffer: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            item_store[write_slot_reg] <= s_item_data;
        end
        if (mem_re) begin
            rdata_reg <= item_store[rd_slot];
        end
    end

    assign m_status             = status_reg;
    assign m_read_data          = rd_pass_reg ? rdata_reg : '0;
    assign m_wake_sender        = wake_s_reg;
    assign m_wake_receiver      = wake_r_reg;
    assign m_inherit_request    = inh_reg;
    assign m_disinherit_request = dis_reg;
    assign m_holder_task        = htask_reg;
    assign m_message_count      = count_reg;

endmodule

/* rtl/rtos_queue_semaphore_mutex_core.sv */
// Top level of the RTOS queue object: controller plus datapath.
// Depends on rqsm_pkg, rqsm_ctrl and rqsm_datapath.
//
// One queue object that acts as a message queue (carries_data = 1), a
// counting semaphore, or a mutex (carries_data = 0, queue_length = 1). Each
// request is a send/give or a receive/take and yields exactly one result.
// A request is executed in the cycle it is accepted; its result is shown
// from the next cycle and held until taken, and the next request is taken
// in the cycle after that, so no new request is taken before the last
// result is taken. The pace is set by the handshake controller, which
// keeps one request in flight so that the count, slot pointers and the
// registered ring buffer read see each request's update before the next.
// Configuration writes are always accepted, must be issued while no request
// is pending, and reload the pointers, count, holder and waiter counters.
// A blocked caller is retried by reissuing the request with may_wait low.
module rtos_queue_semaphore_mutex_core #(
    parameter int QUEUE_DEPTH = rqsm_pkg::DEF_QUEUE_DEPTH,
    parameter int ITEM_BITS   = rqsm_pkg::DEF_ITEM_BITS,
    parameter int MAX_TASKS   = rqsm_pkg::DEF_MAX_TASKS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_kind,
    input  logic [ITEM_BITS-1:0]           s_item_data,
    input  logic [rqsm_pkg::TASK_W-1:0]    s_task_id,
    input  logic                           s_may_wait,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rqsm_pkg::STATUS_W-1:0]  m_status,
    output logic [ITEM_BITS-1:0]           m_read_data,
    output logic                           m_wake_sender,
    output logic                           m_wake_receiver,
    output logic                           m_inherit_request,
    output logic                           m_disinherit_request,
    output logic [rqsm_pkg::TASK_W-1:0]    m_holder_task,
    output logic [rqsm_pkg::COUNT_W-1:0]   m_message_count,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rqsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rqsm_pkg::CFG_W-1:0]     cfg_data
);
    import rqsm_pkg::*;

    logic exec_req;
    logic cfg_write;

    // Configuration writes are always accepted.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    // Request sequencing.
    rqsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .exec_req (exec_req)
    );

    // Queue state and result registers.
    rqsm_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ITEM_BITS   (ITEM_BITS),
        .MAX_TASKS   (MAX_TASKS)
    ) u_datapath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .exec_req             (exec_req),
        .s_kind               (s_kind),
        .s_item_data          (s_item_data),
        .s_task_id            (s_task_id),
        .s_may_wait           (s_may_wait),
        .cfg_write            (cfg_write),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .m_status             (m_status),
        .m_read_data          (m_read_data),
        .m_wake_sender        (m_wake_sender),
        .m_wake_receiver      (m_wake_receiver),
        .m_inherit_request    (m_inherit_request),
        .m_disinherit_request (m_disinherit_request),
        .m_holder_task        (m_holder_task),
        .m_message_count      (m_message_count)
    );

endmodule
